// ----- hdl/qsd_pkg.sv -----
// qsd_pkg: shared types and constants of the QAM soft/hard demapper.
// No dependencies; imported by the top level, lane, reducer and serializer modules.
`default_nettype none

package qsd_pkg;

	localparam int MAX_POINTS_DEF = 16;
	localparam int NUM_SLOTS      = 16;  // constellation slots seen by the reducer
	localparam int NBITS_MAX      = 4;
	localparam int ROOT_W         = 17;  // floor sqrt of a 34-bit sum
	localparam int SQ_W           = 34;
	localparam int DIST_W         = ROOT_W + 1;
	localparam int LANE_LAT       = ROOT_W + 2; // dx/dy, square sum, root steps

	typedef logic [DIST_W-1:0] dist_t;
	localparam dist_t DIST_NONE = '1;  // above any real distance

	typedef enum logic [2:0] {
		CFG_SOFT_MODE = 3'd0,
		CFG_ORDER     = 3'd1,
		CFG_INV_VAR   = 3'd2,
		CFG_PTS_LOW   = 3'd3,
		CFG_PTS_HIGH  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic        soft_en;
		logic        sixteen;
		logic [15:0] inv;
	} mode_t;

	typedef struct packed {
		logic [NBITS_MAX-1:0][15:0] llr;   // indexed by bit position
		logic [NBITS_MAX-1:0]       hard;  // nearest point index
	} sym_res_t;

endpackage

`default_nettype wire

// ----- hdl/qam_soft_hard_demapper_top.sv -----
// A sample's first bit result passes the input register, distance lanes, reducer and
// serializer register; the rest follow back to back, 2 (QPSK) or 4 (16-QAM) in all. Busy
// holds off the next sample until the single result port is free. Receiver cannot stall.
// Async active-low reset restores the default registers.
// Top level: config registers, input throttle, distance lanes, reducer and serializer.
// Depends on qsd_pkg, qsd_lane, qsd_reduce, qsd_serial.
`default_nettype none

module qam_soft_hard_demapper_top import qsd_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [15:0] sym_i,
	input  wire logic signed [15:0] sym_q,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_idx,
	input  wire logic [63:0]        cfg_data,
	output logic                    res_strobe,
	output logic signed [15:0]      llr,
	output logic                    hard_bit,
	output logic                    last
);

	localparam bit HAS16 = MAX_POINTS >= 16;
	localparam int LANES = HAS16 ? 16 : 4;

	logic        soft_q, order_q;
	logic [15:0] inv_q;
	logic [63:0] pts_low_q, pts_high_q;
	mode_t       mode;

	logic [1:0]  wait_q;
	logic        accept;

	logic signed [15:0] si_s1, sq_s1;
	logic               vld_s1;
	logic [LANE_LAT-1:0] vld_pipe_q;

	dist_t [LANES-1:0]     lane_dist;
	dist_t [NUM_SLOTS-1:0] dists;

	logic     red_valid;
	sym_res_t red_res;

	assign mode = '{soft_en: soft_q, sixteen: order_q & HAS16, inv: inv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soft_q     <= 1'b1;
			order_q    <= 1'b1;
			inv_q      <= 16'd256;
			pts_low_q  <= '0;
			pts_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_SOFT_MODE: soft_q     <= cfg_data[0];
				CFG_ORDER:     order_q    <= cfg_data[0];
				CFG_INV_VAR:   inv_q      <= cfg_data[15:0];
				CFG_PTS_LOW:   pts_low_q  <= cfg_data;
				CFG_PTS_HIGH:  pts_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// one transaction per symbol time so the result port never overruns
	assign accept = start & ~busy;
	assign busy   = wait_q != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q     <= '0;
			vld_s1     <= 1'b0;
			vld_pipe_q <= '0;
		end else begin
			if (accept) begin
				wait_q <= mode.sixteen ? 2'd3 : 2'd1;
			end else if (busy) begin
				wait_q <= wait_q - 2'd1;
			end
			vld_s1     <= accept;
			vld_pipe_q <= {vld_pipe_q[LANE_LAT-2:0], vld_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			si_s1 <= sym_i;
			sq_s1 <= sym_q;
		end
	end

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		qsd_lane #(.LANE(k)) u_lane (
			.clk      (clk),
			.sym_i    (si_s1),
			.sym_q    (sq_s1),
			.sixteen  (mode.sixteen),
			.pts_low  (pts_low_q),
			.pts_high (pts_high_q),
			.dist_out (lane_dist[k])
		);
	end

	always_comb begin
		for (int k = 0; k < NUM_SLOTS; k++) begin
			if (k < LANES && (k < 4 || mode.sixteen)) begin
				dists[k] = lane_dist[k % LANES];
			end else begin
				dists[k] = DIST_NONE;
			end
		end
	end

	qsd_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_pipe_q[LANE_LAT-1]),
		.dists     (dists),
		.inv       (mode.inv),
		.out_valid (red_valid),
		.res       (red_res)
	);

	qsd_serial u_serial (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (red_valid),
		.res      (red_res),
		.mode     (mode),
		.strobe   (res_strobe),
		.llr      (llr),
		.hard_bit (hard_bit),
		.last     (last)
	);

endmodule

`default_nettype wire

// ----- hdl/qsd_lane.sv -----
// qsd_lane: distance from the sample to one constellation point.
// Offset, squared sum and a 17-step pipelined integer square root; uses qsd_pkg.
`default_nettype none

module qsd_lane import qsd_pkg::*; #(
	parameter int LANE = 0
) (
	input  wire logic               clk,
	input  wire logic signed [15:0] sym_i,
	input  wire logic signed [15:0] sym_q,
	input  wire logic               sixteen,
	input  wire logic [63:0]        pts_low,
	input  wire logic [63:0]        pts_high,
	output dist_t                   dist_out
);

	localparam logic [3:0] LID = 4'(LANE);
	localparam int RW = SQ_W + 1;

	logic [1:0]         quad, pnt;
	logic [31:0]        word_sel;
	logic signed [16:0] px, py;
	logic signed [17:0] dx, dy;
	logic signed [17:0] dx_s2, dy_s2;
	logic signed [35:0] xx, yy;
	logic [SQ_W-1:0]    sq_s3;
	logic [RW-1:0]      v_s    [1:ROOT_W];
	logic [RW-1:0]      root_s [1:ROOT_W];

	always_comb begin
		pnt = sixteen ? LID[1:0] : 2'b00;
		quad = sixteen ? LID[3:2] : LID[1:0];
		if (pnt[1]) begin
			word_sel = pnt[0] ? pts_high[63:32] : pts_high[31:0];
		end else begin
			word_sel = pnt[0] ? pts_low[63:32] : pts_low[31:0];
		end
		px = {word_sel[15], word_sel[15:0]};
		py = {word_sel[31], word_sel[31:16]};
		// mirrored -32768 becomes +32768, which 17 bits hold
		if (quad[0]) begin
			px = -px;
		end
		if (quad[1]) begin
			py = -py;
		end
		dx = {{2{sym_i[15]}}, sym_i} - {px[16], px};
		dy = {{2{sym_q[15]}}, sym_q} - {py[16], py};
	end

	always_ff @(posedge clk) begin
		dx_s2 <= dx;
		dy_s2 <= dy;
	end

	assign xx = dx_s2 * dx_s2;
	assign yy = dy_s2 * dy_s2;

	always_ff @(posedge clk) begin
		sq_s3 <= xx[SQ_W-1:0] + yy[SQ_W-1:0];
	end

	for (genvar j = 0; j < ROOT_W; j++) begin : g_root
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (ROOT_W - 1 - j));
		logic [RW-1:0] vin, rin, trial;
		if (j == 0) begin : g_first
			assign vin = {1'b0, sq_s3};
			assign rin = '0;
		end else begin : g_next
			assign vin = v_s[j];
			assign rin = root_s[j];
		end
		assign trial = rin + BIT;
		always_ff @(posedge clk) begin
			if (vin >= trial) begin
				v_s[j+1]    <= vin - trial;
				root_s[j+1] <= (rin >> 1) + BIT;
			end else begin
				v_s[j+1]    <= vin;
				root_s[j+1] <= rin >> 1;
			end
		end
	end

	assign dist_out = {1'b0, root_s[ROOT_W][ROOT_W-1:0]};

endmodule

`default_nettype wire

// ----- hdl/qsd_reduce.sv -----
// qsd_reduce: per-bit minimum distances, nearest point and saturated LLRs.
// Four register stages: group minima, global minima, products, scaling; uses qsd_pkg.
`default_nettype none

module qsd_reduce import qsd_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire dist_t [NUM_SLOTS-1:0]  dists,
	input  wire logic [15:0]            inv,
	output logic                        out_valid,
	output sym_res_t                    res
);

	function automatic dist_t dmin(input dist_t a, input dist_t b);
		return (b < a) ? b : a;
	endfunction

	// stage 1: per group of four slots
	dist_t [3:0][1:0][1:0] bmin_s1;  // [group][bit][class], low two index bits
	dist_t [3:0]           gmin_s1;
	logic  [3:0][1:0]      garg_s1;
	logic                  vld_s1;

	// stage 2: over all groups
	dist_t [NBITS_MAX-1:0][1:0] dm_s2;
	logic  [3:0]                best_s2;
	logic                       vld_s2;

	logic signed [35:0] prod_s3 [NBITS_MAX];
	logic [3:0]         best_s3;
	logic               vld_s3;

	sym_res_t res_s4;
	logic     vld_s4;

	always_ff @(posedge clk) begin
		for (int g = 0; g < 4; g++) begin
			dist_t a01, a23;
			logic  i01, i23;
			bmin_s1[g][0][0] <= dmin(dists[4*g],   dists[4*g+2]);
			bmin_s1[g][0][1] <= dmin(dists[4*g+1], dists[4*g+3]);
			bmin_s1[g][1][0] <= dmin(dists[4*g],   dists[4*g+1]);
			bmin_s1[g][1][1] <= dmin(dists[4*g+2], dists[4*g+3]);
			i01 = dists[4*g+1] < dists[4*g];
			a01 = i01 ? dists[4*g+1] : dists[4*g];
			i23 = dists[4*g+3] < dists[4*g+2];
			a23 = i23 ? dists[4*g+3] : dists[4*g+2];
			if (a23 < a01) begin
				gmin_s1[g] <= a23;
				garg_s1[g] <= {1'b1, i23};
			end else begin
				gmin_s1[g] <= a01;
				garg_s1[g] <= {1'b0, i01};
			end
		end
	end

	always_ff @(posedge clk) begin
		dist_t m01, m23;
		logic  g01, g23;
		for (int bp = 0; bp < 2; bp++) begin
			for (int c = 0; c < 2; c++) begin
				dm_s2[bp][c] <= dmin(dmin(bmin_s1[0][bp][c], bmin_s1[1][bp][c]),
					dmin(bmin_s1[2][bp][c], bmin_s1[3][bp][c]));
			end
		end
		// bit 2 of the index is group bit 0, bit 3 is group bit 1
		dm_s2[2][0] <= dmin(gmin_s1[0], gmin_s1[2]);
		dm_s2[2][1] <= dmin(gmin_s1[1], gmin_s1[3]);
		dm_s2[3][0] <= dmin(gmin_s1[0], gmin_s1[1]);
		dm_s2[3][1] <= dmin(gmin_s1[2], gmin_s1[3]);
		// strict compares keep the lower index on ties
		g01 = gmin_s1[1] < gmin_s1[0];
		m01 = g01 ? gmin_s1[1] : gmin_s1[0];
		g23 = gmin_s1[3] < gmin_s1[2];
		m23 = g23 ? gmin_s1[3] : gmin_s1[2];
		if (m23 < m01) begin
			best_s2 <= {1'b1, g23, garg_s1[{1'b1, g23}]};
		end else begin
			best_s2 <= {1'b0, g01, garg_s1[{1'b0, g01}]};
		end
	end

	always_ff @(posedge clk) begin
		for (int bp = 0; bp < NBITS_MAX; bp++) begin
			logic signed [18:0] diff;
			diff = $signed({1'b0, dm_s2[bp][0]}) - $signed({1'b0, dm_s2[bp][1]});
			prod_s3[bp] <= 36'(diff) * 36'($signed({1'b0, inv}));
		end
		best_s3 <= best_s2;
	end

	always_ff @(posedge clk) begin
		for (int bp = 0; bp < NBITS_MAX; bp++) begin
			logic signed [35:0] sh;
			sh = prod_s3[bp] >>> 8;  // arithmetic shift floors
			if (sh > 36'sd32767) begin
				res_s4.llr[bp] <= 16'h7FFF;
			end else if (sh < -36'sd32768) begin
				res_s4.llr[bp] <= 16'h8000;
			end else begin
				res_s4.llr[bp] <= sh[15:0];
			end
		end
		res_s4.hard <= best_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign out_valid = vld_s4;
	assign res       = res_s4;

endmodule

`default_nettype wire

// ----- hdl/qsd_serial.sv -----
// qsd_serial: emits one symbol's bit results, MSB first, one per cycle.
// Registered outputs; uses qsd_pkg.
`default_nettype none

module qsd_serial import qsd_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         load,
	input  wire sym_res_t     res,
	input  wire mode_t        mode,
	output logic              strobe,
	output logic signed [15:0] llr,
	output logic              hard_bit,
	output logic              last
);

	sym_res_t   hold_q;
	logic [1:0] pos_q;
	logic       act_q;
	logic       strobe_q, hard_q, last_q;
	logic [15:0] llr_q;

	logic       emit;
	logic [1:0] pos;
	sym_res_t   src;

	always_comb begin
		emit = load | act_q;
		src  = load ? res : hold_q;
		pos  = load ? (mode.sixteen ? 2'd3 : 2'd1) : pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			pos_q    <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= emit;
			last_q   <= emit && (pos == 2'd0);
			if (emit) begin
				act_q <= pos != 2'd0;
				pos_q <= pos - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hold_q <= res;
		end
		llr_q  <= mode.soft_en ? src.llr[pos] : 16'h0000;
		hard_q <= mode.soft_en ? 1'b0 : src.hard[pos];
	end

	assign strobe   = strobe_q;
	assign llr      = llr_q;
	assign hard_bit = hard_q;
	assign last     = last_q;

endmodule

`default_nettype wire

// ----- hdl/qsd_checker.sv -----
// qsd_checker: port-level assertions for the demapper top level.
// Bound to qam_soft_hard_demapper_top; no package needed.
`default_nettype none

module qsd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        res_strobe,
	input wire logic [15:0] llr,
	input wire logic        hard_bit,
	input wire logic        last
);

	// every symbol has at least two results, so an accept always blocks the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> res_strobe)
		else $error("last without result strobe");

	a_mode_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe |-> (llr == 16'h0000 || !hard_bit))
		else $error("soft and hard values both nonzero");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(res_strobe && !last) |=> res_strobe)
		else $error("symbol results broken off before last");

endmodule

bind qam_soft_hard_demapper_top qsd_checker u_qsd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.res_strobe (res_strobe),
	.llr        (llr),
	.hard_bit   (hard_bit),
	.last       (last)
);

`default_nettype wire
